[sv/pixel_color_match_score_top_defines.svh]
// Assertion macros used by the checker file of the pixel match block.
`ifndef PIXEL_COLOR_MATCH_SCORE_TOP_DEFINES_SVH
`define PIXEL_COLOR_MATCH_SCORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PCMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pixel match check failed");

// Implication with a fixed delay, disabled while reset is low.
`define PCMS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error("pixel match latency check failed");

`endif

[sv/pcms_pkg.sv]
package pcms_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [14:0] score;
        logic [14:0] hue_match;
        logic [14:0] intensity_match;
        logic [14:0] sat_match;
    } t_res;

    typedef enum logic [2:0] {
        CFG_HUE_TX     = 3'd0,
        CFG_HUE_TY     = 3'd1,
        CFG_HUE_WIDTH  = 3'd2,
        CFG_HUE_FADE   = 3'd3,
        CFG_INT_TARGET = 3'd4,
        CFG_INT_WIDTH  = 3'd5,
        CFG_SAT_TARGET = 3'd6,
        CFG_SAT_WIDTH  = 3'd7
    } t_cfg_idx;

    localparam int FRAC_BITS = 14;
    localparam int SQ_STEPS  = 23;
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    localparam int ST_INIT  = 4;
    localparam int ST_IQ    = ST_INIT + FRAC_BITS;
    localparam int ST_ROOT  = ST_INIT + SQ_STEPS;
    localparam int ST_CINIT = ST_ROOT + 1;
    localparam int ST_HINIT = ST_CINIT + FRAC_BITS + 1;
    localparam int ST_HUE   = ST_HINIT + FRAC_BITS + 1;
    localparam int LAT      = ST_HUE + 2;

endpackage

[sv/pixel_color_match_score_top.sv]
// Channel   Ports                                   Handshake
// pixel     start, busy, i_pix                      taken when start is high and busy low
// result    o_valid, o_res                          shown for one cycle while o_valid is high
// config    i_cfg_we, i_cfg_idx, i_cfg_data         written when i_cfg_we is high
//
// One item is taken every cycle.
// Each item passes through the 23-step square root followed by the 14-step cosine
// division and the 14-step hue division, one step per pipeline stage.
// Reset is synchronous and active low; busy is high only while reset is held.
// The result side cannot stall, so the pipeline never holds.
module pixel_color_match_score_top #(
    parameter int PIX_MAX = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pcms_pkg::t_pix     i_pix,
    output logic               o_valid,
    output pcms_pkg::t_res     o_res,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    localparam int PMW = $clog2(PIX_MAX + 1);
    localparam int FPW = PMW + 15;
    localparam int KW  = $clog2(3 * PIX_MAX + 1);
    localparam int DW  = KW + 15;
    localparam int AW  = (DW > 24) ? DW : 24;
    localparam int FB  = pcms_pkg::FRAC_BITS;
    localparam int SQ  = pcms_pkg::SQ_STEPS;
    localparam int DLY = pcms_pkg::ST_HUE - pcms_pkg::ST_IQ;
    localparam int LAT = pcms_pkg::LAT;
    localparam logic [PMW-1:0] PMAX = PMW'(PIX_MAX);
    localparam logic [KW-1:0]  K3P  = KW'(3 * PIX_MAX);

    typedef struct packed {
        logic [24:0]        rem;
        logic [22:0]        root;
        logic [17:0]        l4;
        logic signed [41:0] num;
        logic               hone;
    } t_sq;

    typedef struct packed {
        logic [36:0] rem;
        logic [22:0] root;
        logic [13:0] q;
        logic        neg;
        logic        sat;
        logic        hone;
    } t_cd;

    typedef struct packed {
        logic [15:0] rem;
        logic [13:0] q;
        logic        one;
        logic        zero;
    } t_hd;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [13:0]   q;
        logic          ov;
    } t_idv;

    typedef struct packed {
        logic [24:0] rem;
        logic [13:0] q;
        logic        ov;
    } t_sdv;

    logic signed [15:0] r_htx;
    logic signed [15:0] r_hty;
    logic [15:0]        r_hw;
    logic [14:0]        r_hf;
    logic [14:0]        r_it;
    logic [14:0]        r_iw;
    logic [14:0]        r_st;
    logic [15:0]        r_sw;

    logic [FPW-1:0]     r_fp;
    logic [2*FPW-1:0]   r_fpsq;
    logic [DW-1:0]      r_kit;
    logic [DW-1:0]      r_den;

    logic [LAT:1]       r_vld;

    pcms_pkg::t_pix     r_s1_pix;
    logic signed [10:0] r_s2_x;
    logic signed [8:0]  r_s2_d;
    logic [9:0]         r_s2_sum;
    logic [9:0]         r_s2_hsum;

    logic [17:0]        r_s3_l4;
    logic signed [26:0] r_s3_pxt;
    logic signed [24:0] r_s3_pdy;
    logic [AW-1:0]      r_s3_ia;
    logic [24:0]        r_s3_sn;
    logic [24:0]        r_s3_sd;

    t_sq  r_sq [0:SQ];
    t_sq  n_sq [1:SQ];
    t_cd  r_cd [0:FB];
    t_cd  n_cd [0:FB];
    t_hd  r_hd [0:FB];
    t_hd  n_hd [0:FB];
    t_idv r_id [0:FB];
    t_idv n_id [0:FB];
    t_sdv r_sd [0:FB];
    t_sdv n_sd [0:FB];

    // The saturation divisor travels beside its division.
    logic [24:0] r_sdd [0:FB-1];

    logic [14:0] r_idl [0:DLY-1];
    logic [14:0] r_sdl [0:DLY-1];
    logic [14:0] n_int;
    logic [14:0] n_sat;

    logic [14:0] r_s8_hue;
    logic [14:0] n_hue;
    logic [29:0] r_s9_p1;
    logic [14:0] r_s9_hue;
    logic [14:0] r_s9_int;
    logic [14:0] r_s9_sat;
    pcms_pkg::t_res r_res;

    logic [7:0]         n_m;
    logic [7:0]         n_rp;
    logic [7:0]         n_gp;
    logic [7:0]         n_bp;
    logic signed [21:0] n_xx;
    logic signed [17:0] n_dd;
    logic signed [AW:0] n_idiff;
    logic [23:0]        n_hs;
    logic [24:0]        n_ss;
    logic [14:0]        n_w;
    logic [9:0]         n_dn;
    logic signed [41:0] n_num;
    logic [44:0]        n_p2;

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_htx <= '0;
            r_hty <= '0;
            r_hw  <= 16'd16384;
            r_hf  <= '0;
            r_it  <= 15'd16384;
            r_iw  <= 15'd16384;
            r_st  <= 15'd16384;
            r_sw  <= 16'd16384;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], start && !busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcms_pkg::CFG_HUE_TX:     r_htx <= $signed(i_cfg_data);
                    pcms_pkg::CFG_HUE_TY:     r_hty <= $signed(i_cfg_data);
                    pcms_pkg::CFG_HUE_WIDTH:  r_hw  <= i_cfg_data;
                    pcms_pkg::CFG_HUE_FADE:   r_hf  <= i_cfg_data[14:0];
                    pcms_pkg::CFG_INT_TARGET: r_it  <= i_cfg_data[14:0];
                    pcms_pkg::CFG_INT_WIDTH:  r_iw  <= i_cfg_data[14:0];
                    pcms_pkg::CFG_SAT_TARGET: r_st  <= i_cfg_data[14:0];
                    pcms_pkg::CFG_SAT_WIDTH:  r_sw  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fp   <= r_hf * PMAX;
        r_fpsq <= r_fp * r_fp;
        r_kit  <= r_it * K3P;
        r_den  <= r_iw * K3P;
    end

    always_comb begin
        n_m = r_s1_pix.red;
        if (r_s1_pix.green < n_m) begin
            n_m = r_s1_pix.green;
        end
        if (r_s1_pix.blue < n_m) begin
            n_m = r_s1_pix.blue;
        end
        n_rp = r_s1_pix.red - n_m;
        n_gp = r_s1_pix.green - n_m;
        n_bp = r_s1_pix.blue - n_m;
    end

    always_comb begin
        n_xx    = r_s2_x * r_s2_x;
        n_dd    = r_s2_d * r_s2_d;
        n_idiff = $signed({1'b0, AW'({r_s2_sum, 14'b0})}) - $signed({1'b0, AW'(r_kit)});
        n_hs    = {r_s2_hsum, 14'b0};
        n_ss    = r_st * r_s2_sum;
        n_w     = (r_sw == 16'd0) ? pcms_pkg::ONE_Q14 : r_sw[14:0];
        n_dn    = (r_s2_sum == 10'd0) ? 10'd1 : r_s2_sum;
        n_num   = (42'(r_s3_pxt) <<< 14) + 42'(r_s3_pdy) * 42'sd28378;
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_pix;
        r_s2_x    <= $signed({2'b00, n_rp, 1'b0}) - $signed({3'b000, n_gp})
                     - $signed({3'b000, n_bp});
        r_s2_d    <= $signed({1'b0, n_gp}) - $signed({1'b0, n_bp});
        r_s2_sum  <= 10'(r_s1_pix.red) + 10'(r_s1_pix.green) + 10'(r_s1_pix.blue);
        r_s2_hsum <= 10'(n_rp) + 10'(n_gp) + 10'(n_bp);
        r_s3_l4   <= 18'($unsigned(n_xx)) + 18'($unsigned(n_dd)) * 18'd3;
        r_s3_pxt  <= r_s2_x * r_htx;
        r_s3_pdy  <= r_s2_d * r_hty;
        r_s3_ia   <= n_idiff[AW] ? AW'(-n_idiff) : AW'(n_idiff);
        if (r_s2_sum != 10'd0) begin
            r_s3_sn <= ({1'b0, n_hs} >= n_ss) ? 25'({1'b0, n_hs} - n_ss)
                                              : 25'(n_ss - {1'b0, n_hs});
        end else begin
            r_s3_sn <= 25'(r_st);
        end
        r_s3_sd   <= n_dn * n_w;

        r_sq[0].rem  <= '0;
        r_sq[0].root <= '0;
        r_sq[0].l4   <= r_s3_l4;
        r_sq[0].num  <= n_num;
        r_sq[0].hone <= r_hw[15] || (r_s3_l4 == 18'd0) || ({r_s3_l4, 26'b0} < r_fpsq);

        r_id[0].ov  <= (r_s3_ia >= AW'(r_den));
        r_id[0].rem <= r_s3_ia[DW-1:0];
        r_id[0].q   <= '0;
        r_sd[0].ov  <= (r_s3_sn >= r_s3_sd);
        r_sd[0].rem <= r_s3_sn;
        r_sd[0].q   <= '0;
        r_sdd[0]    <= r_s3_sd;
    end

    always_comb begin
        logic [45:0] v;
        logic [26:0] remx;
        logic [24:0] trial;
        for (int k = 1; k <= SQ; k++) begin
            v     = {r_sq[k-1].l4, 28'b0};
            remx  = {r_sq[k-1].rem, v[45-2*(k-1) -: 2]};
            trial = {r_sq[k-1].root, 2'b01};
            n_sq[k] = r_sq[k-1];
            if (remx >= 27'(trial)) begin
                n_sq[k].rem  = 25'(remx - 27'(trial));
                n_sq[k].root = {r_sq[k-1].root[21:0], 1'b1};
            end else begin
                n_sq[k].rem  = remx[24:0];
                n_sq[k].root = {r_sq[k-1].root[21:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [40:0] mag;
        logic [36:0] trial;
        mag = r_sq[SQ].num[41] ? 41'(-r_sq[SQ].num) : 41'(r_sq[SQ].num);
        n_cd[0].rem  = mag[36:0];
        n_cd[0].root = r_sq[SQ].root;
        n_cd[0].q    = '0;
        n_cd[0].neg  = r_sq[SQ].num[41];
        n_cd[0].sat  = (mag >= 41'({r_sq[SQ].root, 14'b0}));
        n_cd[0].hone = r_sq[SQ].hone;
        for (int c = 1; c <= FB; c++) begin
            trial   = 37'(r_cd[c-1].root) << (FB - c);
            n_cd[c] = r_cd[c-1];
            if (r_cd[c-1].rem >= trial) begin
                n_cd[c].rem        = r_cd[c-1].rem - trial;
                n_cd[c].q[FB - c]  = 1'b1;
            end
        end
    end

    always_comb begin
        logic               hw0;
        logic signed [16:0] cosv;
        logic signed [16:0] t;
        logic [16:0]        rem2;
        hw0  = (r_hw == 16'd0);
        cosv = r_cd[FB].neg ? -$signed({3'b000, r_cd[FB].q}) : $signed({3'b000, r_cd[FB].q});
        t    = 17'sd16384 - cosv;
        n_hd[0].rem  = t[15:0];
        n_hd[0].q    = '0;
        n_hd[0].one  = r_cd[FB].hone || (!hw0 && r_cd[FB].sat && !r_cd[FB].neg);
        n_hd[0].zero = !r_cd[FB].hone && (hw0 || (r_cd[FB].sat && r_cd[FB].neg)
                       || (!r_cd[FB].sat && (t[15:0] >= r_hw)));
        for (int h = 1; h <= FB; h++) begin
            rem2    = {r_hd[h-1].rem, 1'b0};
            n_hd[h] = r_hd[h-1];
            if (rem2 >= {1'b0, r_hw}) begin
                n_hd[h].rem = 16'(rem2 - {1'b0, r_hw});
                n_hd[h].q   = {r_hd[h-1].q[12:0], 1'b1};
            end else begin
                n_hd[h].rem = rem2[15:0];
                n_hd[h].q   = {r_hd[h-1].q[12:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [DW:0] irem2;
        logic [25:0] srem2;
        n_id[0] = r_id[0];
        n_sd[0] = r_sd[0];
        for (int j = 1; j <= FB; j++) begin
            irem2   = {r_id[j-1].rem, 1'b0};
            n_id[j] = r_id[j-1];
            if (irem2 >= {1'b0, r_den}) begin
                n_id[j].rem = DW'(irem2 - {1'b0, r_den});
                n_id[j].q   = {r_id[j-1].q[12:0], 1'b1};
            end else begin
                n_id[j].rem = irem2[DW-1:0];
                n_id[j].q   = {r_id[j-1].q[12:0], 1'b0};
            end
            srem2   = {r_sd[j-1].rem, 1'b0};
            n_sd[j] = r_sd[j-1];
            if (srem2 >= {1'b0, r_sdd[j-1]}) begin
                n_sd[j].rem = 25'(srem2 - {1'b0, r_sdd[j-1]});
                n_sd[j].q   = {r_sd[j-1].q[12:0], 1'b1};
            end else begin
                n_sd[j].rem = srem2[24:0];
                n_sd[j].q   = {r_sd[j-1].q[12:0], 1'b0};
            end
        end
        n_int = r_id[FB].ov ? 15'd0 : pcms_pkg::ONE_Q14 - 15'(r_id[FB].q);
        if (r_sw > 16'd16384) begin
            n_sat = pcms_pkg::ONE_Q14;
        end else begin
            n_sat = r_sd[FB].ov ? 15'd0 : pcms_pkg::ONE_Q14 - 15'(r_sd[FB].q);
        end
        if (r_hd[FB].one) begin
            n_hue = pcms_pkg::ONE_Q14;
        end else if (r_hd[FB].zero) begin
            n_hue = '0;
        end else begin
            n_hue = pcms_pkg::ONE_Q14 - 15'(r_hd[FB].q);
        end
        n_p2 = r_s9_p1 * r_s9_sat;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= SQ; k++) begin
            r_sq[k] <= n_sq[k];
        end
        r_cd[0] <= n_cd[0];
        r_hd[0] <= n_hd[0];
        for (int c = 1; c <= FB; c++) begin
            r_cd[c] <= n_cd[c];
            r_hd[c] <= n_hd[c];
            r_id[c] <= n_id[c];
            r_sd[c] <= n_sd[c];
        end
        for (int s = 1; s < FB; s++) begin
            r_sdd[s] <= r_sdd[s-1];
        end
        r_idl[0] <= n_int;
        r_sdl[0] <= n_sat;
        for (int j = 1; j < DLY; j++) begin
            r_idl[j] <= r_idl[j-1];
            r_sdl[j] <= r_sdl[j-1];
        end
        r_s8_hue <= n_hue;
        r_s9_p1  <= r_s8_hue * r_idl[DLY-1];
        r_s9_hue <= r_s8_hue;
        r_s9_int <= r_idl[DLY-1];
        r_s9_sat <= r_sdl[DLY-1];
        r_res.score           <= n_p2[42:28];
        r_res.hue_match       <= r_s9_hue;
        r_res.intensity_match <= r_s9_int;
        r_res.sat_match       <= r_s9_sat;
    end

    assign o_valid = r_vld[LAT];
    assign o_res   = r_res;

endmodule

[sv/pcms_chk.sv]
`include "pixel_color_match_score_top_defines.svh"

module pcms_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input pcms_pkg::t_res o_res
);

    `PCMS_ASSERT_DLY(a_item_latency, i_clk, i_rst_n, start && !busy, pcms_pkg::LAT, o_valid)

    `PCMS_ASSERT_IMP(a_no_extra_result, i_clk, i_rst_n, o_valid, $past(start && !busy, pcms_pkg::LAT))

    `PCMS_ASSERT_IMP(a_score_bound, i_clk, i_rst_n, o_valid, (o_res.score <= o_res.hue_match) && (o_res.score <= o_res.intensity_match) && (o_res.score <= o_res.sat_match))

    `PCMS_ASSERT_IMP(a_zero_factor, i_clk, i_rst_n, o_valid && (o_res.hue_match == 15'd0 || o_res.intensity_match == 15'd0 || o_res.sat_match == 15'd0), o_res.score == 15'd0)

endmodule

bind pixel_color_match_score_top pcms_chk u_pcms_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
